/* hw/rtl/rsi_with_threshold_alerts_unit_macros.svh */
// Assertion macros for the RSI alert unit.
// Used by the top level only; no other dependencies.
`ifndef RSI_WITH_THRESHOLD_ALERTS_UNIT_MACROS_SVH
`define RSI_WITH_THRESHOLD_ALERTS_UNIT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define RSI_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rsi unit assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define RSI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rsi unit assertion failed");

`endif

/* hw/rtl/rsi_pkg.sv */
// Shared constants, codes and state types for the RSI alert unit.
// No dependencies.
package rsi_pkg;

  localparam int MAX_PERIOD_DEF = 255;
  localparam int PRICE_BITS_DEF = 32;

  localparam int PRICE_W     = 32;
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 24;
  localparam int CFG_W       = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int LINE_W      = 7;
  localparam int RSI_W       = 15;
  localparam int ALERT_W     = 2;
  localparam int SCALE_SHIFT = 8;   // RSI * 256
  localparam int MUL_EXTRA   = 7;   // bits added by the * 100 step

  localparam logic [RSI_W-1:0] RSI_FULL = 15'd25600;
  localparam logic [RSI_W-1:0] RSI_HALF = 15'd12800;

  localparam logic [CFG_W-1:0]  PERIOD_RST = 8'd14;
  localparam logic [LINE_W-1:0] BUY_RST    = 7'd25;
  localparam logic [LINE_W-1:0] SELL_RST   = 7'd75;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUY_LINE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SELL_LINE     = 2'd2;

  localparam logic [ALERT_W-1:0] ALERT_NONE = 2'd0;
  localparam logic [ALERT_W-1:0] ALERT_BUY  = 2'd1;
  localparam logic [ALERT_W-1:0] ALERT_SELL = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_DROP,
    ST_START,
    ST_WAIT,
    ST_OUT
  } rsi_state_e;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_LOAD,
    DV_ITER,
    DV_DONE
  } div_state_e;

endpackage

/* hw/rtl/rsi_with_threshold_alerts_unit.sv */
// RSI unit: each accepted price passes the add and drop steps; once the window is full the
// unit starts the 15-step bit-serial divider (its steps are skipped when gain and loss are
// both zero) and then loads the result word into the output register. No new price is taken
// before that load. The output register lets the next price in while a result waits. Reset is
// asynchronous, active low: registers to their defaults, counters and sums to zero; the price ring is not cleared.
`include "rsi_with_threshold_alerts_unit_macros.svh"

module rsi_with_threshold_alerts_unit import rsi_pkg::*; #(
  parameter int MAX_PERIOD = MAX_PERIOD_DEF,
  parameter int PRICE_BITS = PRICE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [31:0] price_sample
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [14:0] rsi_value, [16:15] alert_state
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i
);

  localparam int DEPTH  = MAX_PERIOD + 1;
  localparam int AW     = $clog2(DEPTH);
  localparam int AX     = AW + 1;
  localparam int PW     = (PRICE_BITS < PRICE_W) ? PRICE_BITS : PRICE_W;
  localparam int SUM_W  = PW + $clog2(DEPTH);
  localparam int SEEN_W = $clog2(MAX_PERIOD + 2);
  localparam int CW     = (SEEN_W > CFG_W) ? SEEN_W : CFG_W;
  localparam int PAD_W  = OUT_DATA_W - RSI_W - ALERT_W;

  rsi_state_e         state_q, state_d;
  logic [CFG_W-1:0]   period_q;
  logic [LINE_W-1:0]  buy_q;
  logic [LINE_W-1:0]  sell_q;
  logic [AW-1:0]      pos_q;
  logic [SEEN_W-1:0]  seen_q;
  logic [SUM_W-1:0]   gain_q;
  logic [SUM_W-1:0]   loss_q;
  logic [PW-1:0]      price_q;
  logic [PW-1:0]      prev_q;
  logic               first_q;
  logic [RSI_W-1:0]   rsi_q;
  logic [RSI_W-1:0]   prev_rsi_q;
  logic [ALERT_W-1:0] alert_q;
  logic               m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;

  logic               accept;
  logic               out_free;
  logic               div_start;
  logic               div_done;
  logic [RSI_W-1:0]   div_quot;
  logic               restart;

  logic [PW-1:0]      price_in;
  logic [CW-1:0]      period_ext;
  logic [CW-1:0]      period_clip;
  logic [SEEN_W-1:0]  period_eff;
  logic [AX-1:0]      k_a, k_b, sum_a, sum_b, wrap_a, wrap_b;
  logic [AW-1:0]      raddr_a, raddr_b;
  logic [PW-1:0]      rd_newer, rd_older;

  logic               add_up;
  logic [PW-1:0]      add_mag;
  logic               drop_up;
  logic [PW-1:0]      drop_mag;

  logic               buy_hit, sell_hit;
  logic [ALERT_W-1:0] alert_calc, alert_nx;

  assign price_in = s_axis_tdata[PW-1:0];
  assign restart  = cfg_we_i && (cfg_index_i == REG_WINDOW_PERIOD);

  // effective period: zero counts as one, clipped to MAX_PERIOD, one less than the ring depth
  assign period_ext  = CW'(period_q);
  assign period_clip = (period_q == '0) ? CW'(1) :
                       (period_ext > CW'(MAX_PERIOD)) ? CW'(MAX_PERIOD) : period_ext;
  assign period_eff  = period_clip[SEEN_W-1:0];

  assign k_a    = AX'(period_eff);
  assign k_b    = k_a + 1'b1;
  assign sum_a  = AX'(pos_q) + AX'(DEPTH) - k_a;
  assign sum_b  = AX'(pos_q) + AX'(DEPTH) - k_b;
  assign wrap_a = (sum_a >= AX'(DEPTH)) ? sum_a - AX'(DEPTH) : sum_a;
  assign wrap_b = (sum_b >= AX'(DEPTH)) ? sum_b - AX'(DEPTH) : sum_b;
  assign raddr_a = wrap_a[AW-1:0];
  assign raddr_b = wrap_b[AW-1:0];

  rsi_ring #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .W     (PW)
  ) u_ring (
    .clk_i     (clk_i),
    .we_i      (accept),
    .waddr_i   (pos_q),
    .wdata_i   (price_in),
    .re_i      (accept),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rd_newer),
    .rdata_b_o (rd_older)
  );

  rsi_div #(
    .SUM_W (SUM_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .gain_i  (gain_q),
    .loss_i  (loss_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign add_up   = price_q > prev_q;
  assign add_mag  = add_up ? price_q - prev_q : prev_q - price_q;
  assign drop_up  = rd_newer > rd_older;
  assign drop_mag = drop_up ? rd_newer - rd_older : rd_older - rd_newer;

  assign buy_hit  = (rsi_q <= {buy_q, {SCALE_SHIFT{1'b0}}}) && (rsi_q > prev_rsi_q);
  assign sell_hit = (rsi_q >= {sell_q, {SCALE_SHIFT{1'b0}}}) && (rsi_q < prev_rsi_q);

  always_comb begin
    alert_calc = alert_q;
    unique case (alert_q)
      ALERT_SELL: begin
        if (buy_hit) alert_calc = ALERT_BUY;
      end
      ALERT_BUY: begin
        if (sell_hit) alert_calc = ALERT_SELL;
      end
      default: begin
        if (buy_hit) alert_calc = ALERT_BUY;
        else if (sell_hit) alert_calc = ALERT_SELL;
      end
    endcase
    alert_nx = first_q ? alert_q : alert_calc;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) state_d = ST_ADD;
      end
      ST_ADD: begin
        state_d = ST_DROP;
      end
      ST_DROP: begin
        state_d = (seen_q >= period_eff) ? ST_START : ST_IDLE;
      end
      ST_START: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    div_start     = (state_q == ST_START);
    out_free      = !m_valid_q || m_axis_tready;
    accept        = s_axis_tvalid && s_axis_tready;
    m_axis_tvalid = m_valid_q;
    m_axis_tdata  = m_data_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      period_q   <= PERIOD_RST;
      buy_q      <= BUY_RST;
      sell_q     <= SELL_RST;
      pos_q      <= '0;
      seen_q     <= '0;
      gain_q     <= '0;
      loss_q     <= '0;
      prev_rsi_q <= '0;
      alert_q    <= ALERT_NONE;
      m_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (accept) begin
        pos_q <= (pos_q == AW'(DEPTH - 1)) ? '0 : pos_q + 1'b1;
      end

      if (state_q == ST_ADD && seen_q != '0) begin
        if (add_up) gain_q <= gain_q + {{(SUM_W-PW){1'b0}}, add_mag};
        else        loss_q <= loss_q + {{(SUM_W-PW){1'b0}}, add_mag};
      end

      if (state_q == ST_DROP) begin
        if (seen_q > period_eff) begin
          if (drop_up) gain_q <= gain_q - {{(SUM_W-PW){1'b0}}, drop_mag};
          else         loss_q <= loss_q - {{(SUM_W-PW){1'b0}}, drop_mag};
        end
        if (seen_q <= period_eff) seen_q <= seen_q + 1'b1;
      end

      if (state_q == ST_OUT && out_free) begin
        m_valid_q  <= 1'b1;
        alert_q    <= alert_nx;
        prev_rsi_q <= rsi_q;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_WINDOW_PERIOD: period_q <= cfg_wdata_i;
          REG_BUY_LINE:      buy_q    <= cfg_wdata_i[LINE_W-1:0];
          REG_SELL_LINE:     sell_q   <= cfg_wdata_i[LINE_W-1:0];
          default: begin
          end
        endcase
      end

      // period write restarts the warm-up
      if (restart) begin
        seen_q     <= '0;
        gain_q     <= '0;
        loss_q     <= '0;
        prev_rsi_q <= '0;
        alert_q    <= ALERT_NONE;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      price_q <= price_in;
    end
    if (state_q == ST_ADD) begin
      prev_q <= price_q;
    end
    if (state_q == ST_DROP) begin
      first_q <= (seen_q == period_eff);
    end
    if (state_q == ST_WAIT && div_done) begin
      rsi_q <= div_quot;
    end
    if (state_q == ST_OUT && out_free) begin
      m_data_q <= {{PAD_W{1'b0}}, alert_nx, rsi_q};
    end
  end

  `RSI_ASSERT(a_rsi_range, clk_i, rst_ni, (m_valid_q |-> (m_data_q[RSI_W-1:0] <= RSI_FULL)))
  `RSI_ASSERT(a_div_done_waits, clk_i, rst_ni, (div_done |-> (state_q == ST_WAIT)))
  `RSI_ASSERT_NEXT(a_out_load, clk_i, rst_ni, (state_q == ST_OUT) && !m_valid_q, m_valid_q && (state_q == ST_IDLE))

endmodule

/* hw/rtl/rsi_ring.sv */
// Price ring memory: one write port, two registered read ports.
// Depends on nothing but its parameters.
module rsi_ring #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int W     = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_a_i,
  input  logic [AW-1:0] raddr_b_i,
  output logic [W-1:0]  rdata_a_o,
  output logic [W-1:0]  rdata_b_o
);

  logic [W-1:0] mem_q [DEPTH];

  // read returns the old entry when the same address is written
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

/* hw/rtl/rsi_div.sv */
// Bit-serial scaled ratio: floor(gain * 25600 / (gain + loss)), one quotient bit a cycle.
// Depends on rsi_pkg. Gives 12800 when gain and loss are both zero.
module rsi_div import rsi_pkg::*; #(
  parameter int SUM_W = 40
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SUM_W-1:0] gain_i,
  input  logic [SUM_W-1:0] loss_i,
  output logic             done_o,
  output logic [RSI_W-1:0] quot_o
);

  localparam int M_W      = SUM_W + MUL_EXTRA;
  localparam int LOW_KEEP = RSI_W - SCALE_SHIFT;
  localparam int CNT_W    = $clog2(RSI_W);

  div_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q;
  logic [SUM_W-1:0] gain_q;
  logic [SUM_W-1:0] total_q;
  logic [M_W-1:0]   acc_q;
  logic [SUM_W-1:0] rem_q;
  logic [RSI_W-1:0] low_q;
  logic [RSI_W-1:0] quot_q;

  logic [M_W-1:0]   gain_in_ext;
  logic [M_W-1:0]   gain_ext;
  logic [M_W-1:0]   prod;
  logic [SUM_W:0]   shifted;
  logic [SUM_W:0]   diff;
  logic             fits;

  assign gain_in_ext = {{MUL_EXTRA{1'b0}}, gain_i};
  assign gain_ext    = {{MUL_EXTRA{1'b0}}, gain_q};
  // gain * 100 = gain * (64 + 32) + gain * 4; the first part is registered at start, the second added here
  assign prod        = acc_q + (gain_ext << 2);
  assign shifted     = {rem_q, low_q[RSI_W-1]};
  assign diff        = shifted - {1'b0, total_q};
  assign fits        = shifted >= {1'b0, total_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      DV_IDLE: begin
        if (start_i) state_d = DV_LOAD;
      end
      DV_LOAD: begin
        state_d = (total_q == '0) ? DV_DONE : DV_ITER;
      end
      DV_ITER: begin
        if (cnt_q == CNT_W'(RSI_W - 1)) state_d = DV_DONE;
      end
      DV_DONE: begin
        state_d = DV_IDLE;
      end
      default: state_d = DV_IDLE;
    endcase
  end

  always_comb begin
    done_o = (state_q == DV_DONE);
    quot_o = (quot_q > RSI_FULL) ? RSI_FULL : quot_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == DV_LOAD) begin
        cnt_q <= '0;
      end else if (state_q == DV_ITER) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      DV_IDLE: begin
        if (start_i) begin
          gain_q  <= gain_i;
          total_q <= gain_i + loss_i;
          acc_q   <= (gain_in_ext << 6) + (gain_in_ext << 5);
        end
      end
      DV_LOAD: begin
        // top part of the numerator is already below the divisor
        rem_q  <= prod[M_W-1:LOW_KEEP];
        low_q  <= {prod[LOW_KEEP-1:0], {SCALE_SHIFT{1'b0}}};
        quot_q <= RSI_HALF;
      end
      DV_ITER: begin
        rem_q  <= fits ? diff[SUM_W-1:0] : shifted[SUM_W-1:0];
        low_q  <= {low_q[RSI_W-2:0], 1'b0};
        quot_q <= {quot_q[RSI_W-2:0], fits};
      end
      default: begin
      end
    endcase
  end

endmodule
